### rtl/rgbc3_pkg.sv
// ----------------------------------------------------------------------------
// rgbc3_pkg
// Types and constants for the streaming 3x3 RGB convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbc3_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 4096;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int FracBits  = 8;
  localparam int CoefW     = 16;
  localparam int KSize     = 3;
  localparam int Taps      = KSize * KSize;
  localparam int ProdW     = CoefW + 9;
  localparam int SumW      = ProdW + 4;
  localparam int CfgW      = 48;

  typedef enum logic [2:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_COEF_TOP     = 3'd2,
    CFG_COEF_MID     = 3'd3,
    CFG_COEF_BOT     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       run_end;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic [7:0]      alpha;
    logic [2:0][7:0] rgb;
  } pixel_t;

  typedef pixel_t [Taps-1:0] taps_t;

  typedef logic signed [CoefW-1:0] coef_t;
  typedef coef_t [Taps-1:0] kernel_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic       run_end;
    logic       frame_end;
  } tag_t;

endpackage

`default_nettype wire

### rtl/rgbc3_filt.sv
// ----------------------------------------------------------------------------
// rgbc3_filt
// Multiply, sum and saturate pipeline for one 3x3 window request per cycle unless out_stall holds it.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbc3_filt import rgbc3_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      issue_valid,
  output logic           issue_ready,
  input  wire taps_t     issue_taps,
  input  wire tag_t      issue_tag,
  input  wire kernel_t   kernel,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic e_valid, m_valid, s_valid;
  logic o_rdy, s_rdy, m_rdy;
  taps_t e_taps;
  tag_t  e_tag, m_tag, s_tag;
  logic signed [ProdW-1:0] prod_next [3][Taps];
  logic signed [ProdW-1:0] prod [3][Taps];
  logic signed [SumW-1:0]  sum_next [3];
  logic signed [SumW-1:0]  sum [3];

  function automatic logic [7:0] sat(input logic signed [SumW-1:0] s);
    logic [7:0] q;
    if (s < 0) begin
      q = 8'd0;
    end else if (s[SumW-1:FracBits+8] != '0) begin
      q = 8'hFF;
    end else begin
      q = s[FracBits+7:FracBits];
    end
    return q;
  endfunction

  assign o_rdy       = !out_valid || !out_stall;
  assign s_rdy       = !s_valid || o_rdy;
  assign m_rdy       = !m_valid || s_rdy;
  assign issue_ready = !e_valid || m_rdy;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int t = 0; t < Taps; t++) begin
        prod_next[ch][t] = ProdW'($signed({1'b0, e_taps[t].rgb[ch]})) * ProdW'(kernel[t]);
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_next[ch] = '0;
      for (int t = 0; t < Taps; t++) begin
        sum_next[ch] = sum_next[ch] + SumW'(prod[ch][t]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid   <= 1'b0;
      m_valid   <= 1'b0;
      s_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue_ready) e_valid <= issue_valid;
      if (m_rdy) m_valid <= e_valid;
      if (s_rdy) s_valid <= m_valid;
      if (o_rdy) out_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_ready && issue_valid) begin
      e_taps <= issue_taps;
      e_tag  <= issue_tag;
    end
    if (m_rdy && e_valid) begin
      prod  <= prod_next;
      m_tag <= e_tag;
    end
    if (s_rdy && m_valid) begin
      sum   <= sum_next;
      s_tag <= m_tag;
    end
    if (o_rdy && s_valid) begin
      out_data.out_red   <= sat(sum[0]);
      out_data.out_green <= sat(sum[1]);
      out_data.out_blue  <= sat(sum[2]);
      out_data.out_alpha <= s_tag.alpha;
      out_data.run_end   <= s_tag.run_end;
      out_data.frame_end <= s_tag.frame_end;
    end
  end

endmodule

`default_nettype wire

### rtl/rgb_conv3x3_replicate_border.sv
// Path: an accepted pixel passes s1, the window, then filter stages e, m, s and out.
// Throughput: one pixel per cycle unless out_stall holds it; a pixel that yields n
//   results (up to 4, at row ends and on the last row) holds input until all issue.
// Line stores: two 1024 x 32 single-port-write memories, one read per pixel.
// Reset: clears counters, configuration, window, job mask and pipeline valids; line stores are not cleared.
// ----------------------------------------------------------------------------
// rgb_conv3x3_replicate_border
// Streaming 3x3 RGB convolution with replicated borders and alpha pass-through.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_conv3x3_replicate_border import rgbc3_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_wr_en,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [CfgW-1:0] cfg_data,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire in_item_t        in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output out_item_t            out_data
);

  logic [10:0]     frame_width;
  logic [12:0]     frame_height;
  logic [CfgW-1:0] coef_top, coef_mid, coef_bot;
  kernel_t         kernel;

  logic [ColW-1:0] col_count;
  logic [RowW-1:0] row_count;
  logic [10:0]     fw_m1;
  logic [12:0]     fh_m1;
  logic [ColW-1:0] w_last;
  logic [RowW-1:0] h_last;
  logic            row_end, last_row, accept, commit;

  logic            s1_valid, s1_first_row, s1_top, s1_first_col, s1_row_end, s1_last_row;
  logic [ColW-1:0] s1_col;
  pixel_t          s1_pix;

  logic [31:0] mem_upper [MaxWidth];
  logic [31:0] mem_lower [MaxWidth];
  logic [31:0] upper_q, lower_q, fwd_upper, fwd_lower;
  logic        fwd;
  pixel_t      up_data, lo_data;
  pixel_t      col [KSize];
  pixel_t      win [KSize][KSize];

  logic [3:0] job_mask, new_mask, sel;
  logic       job_frame, issue, issue_ready, sel_last, job_free, pass1, use_last;
  taps_t      taps;
  tag_t       tag;
  int         wr, wc;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 11'd1;
      frame_height <= 13'd1;
      coef_top     <= '0;
      coef_mid     <= CfgW'(48'h0000_0100_0000);
      coef_bot     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[10:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[12:0];
        CFG_COEF_TOP:     coef_top     <= cfg_data;
        CFG_COEF_MID:     coef_mid     <= cfg_data;
        CFG_COEF_BOT:     coef_bot     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int l = 0; l < KSize; l++) begin
      kernel[l]           = coef_top[CoefW*l +: CoefW];
      kernel[KSize + l]   = coef_mid[CoefW*l +: CoefW];
      kernel[2*KSize + l] = coef_bot[CoefW*l +: CoefW];
    end
  end

  assign fw_m1 = frame_width - 11'd1;
  assign fh_m1 = frame_height - 13'd1;

  always_comb begin
    if (frame_width == '0) begin
      w_last = '0;
    end else if (frame_width > 11'(MaxWidth)) begin
      w_last = ColW'(MaxWidth - 1);
    end else begin
      w_last = fw_m1[ColW-1:0];
    end
    if (frame_height == '0) begin
      h_last = '0;
    end else if (frame_height > 13'(MaxHeight)) begin
      h_last = RowW'(MaxHeight - 1);
    end else begin
      h_last = fh_m1[RowW-1:0];
    end
  end

  assign row_end  = col_count >= w_last;
  assign last_row = row_count >= h_last;
  assign in_stall = s1_valid && !commit;
  assign accept   = in_valid && !in_stall;

  // advance raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_count <= '0;
        row_count <= last_row ? '0 : row_count + RowW'(1);
      end else begin
        col_count <= col_count + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd      <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        fwd      <= commit && (s1_col == col_count);
      end else if (commit) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix       <= {in_data.in_alpha, in_data.in_blue, in_data.in_green, in_data.in_red};
      s1_col       <= col_count;
      s1_first_row <= row_count == '0;
      s1_top       <= row_count != '0;
      s1_first_col <= col_count == '0;
      s1_row_end   <= row_end;
      s1_last_row  <= last_row;
      upper_q      <= mem_upper[col_count];
      lower_q      <= mem_lower[col_count];
      fwd_upper    <= col[1];
      fwd_lower    <= s1_pix;
    end
    if (commit) begin
      mem_upper[s1_col] <= col[1];
      mem_lower[s1_col] <= s1_pix;
    end
  end

  assign up_data = fwd ? fwd_upper : upper_q;
  assign lo_data = fwd ? fwd_lower : lower_q;

  always_comb begin
    col[0] = s1_first_row ? s1_pix : up_data;
    col[1] = s1_first_row ? s1_pix : lo_data;
    col[2] = s1_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < KSize; k++) begin
        for (int l = 0; l < KSize; l++) begin
          win[k][l] <= '0;
        end
      end
    end else if (commit) begin
      for (int k = 0; k < KSize; k++) begin
        if (s1_first_col) begin
          win[k][0] <= col[k];
          win[k][1] <= col[k];
        end else begin
          win[k][0] <= win[k][1];
          win[k][1] <= win[k][2];
        end
        win[k][2] <= col[k];
      end
    end
  end

  assign new_mask = {s1_row_end && s1_last_row, s1_row_end && s1_top,
                     !s1_first_col && s1_last_row, !s1_first_col && s1_top};
  assign sel      = job_mask & (~job_mask + 4'd1);
  assign sel_last = (job_mask & ~sel) == '0;
  assign issue    = (job_mask != '0) && issue_ready;
  assign job_free = (job_mask == '0) || (issue && sel_last);
  assign commit   = s1_valid && job_free;
  assign pass1    = sel[2] || sel[3];
  assign use_last = sel[1] || sel[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      job_mask  <= '0;
      job_frame <= 1'b0;
    end else if (commit) begin
      job_mask  <= new_mask;
      job_frame <= s1_row_end && s1_last_row;
    end else if (issue) begin
      job_mask  <= job_mask & ~sel;
    end
  end

  always_comb begin
    wr = 0;
    wc = 0;
    for (int k = 0; k < KSize; k++) begin
      for (int l = 0; l < KSize; l++) begin
        wr = use_last ? ((k == 0) ? 1 : 2) : k;
        wc = pass1 ? ((l == 0) ? 1 : 2) : l;
        taps[k*KSize + l] = win[wr][wc];
      end
    end
    tag.alpha     = taps[KSize + 1].alpha;
    tag.run_end   = sel_last;
    tag.frame_end = sel_last && job_frame;
  end

  rgbc3_filt u_filt (
    .clk         (clk),
    .rst         (rst),
    .issue_valid (job_mask != '0),
    .issue_ready (issue_ready),
    .issue_taps  (taps),
    .issue_tag   (tag),
    .kernel      (kernel),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire
